>>> rtl/strip_cluster_centroid_unit_macros.svh
// Assertion macros shared by the strip cluster centroid RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef STRIP_CLUSTER_CENTROID_UNIT_MACROS_SVH
`define STRIP_CLUSTER_CENTROID_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/scc_pkg.sv
// Types and constants shared by the strip cluster centroid modules.
// Depends on nothing.
package scc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STRIP_PITCH   = 2'd0;
    localparam logic [1:0] CFG_CENTRE_OFFSET = 2'd1;
    localparam logic [1:0] CFG_SIDE_STRIPS   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] PITCH_RESET  = 16'd12800;
    localparam logic [15:0] OFFSET_RESET = 16'd0;
    localparam logic [5:0]  SIDE_RESET   = 6'd10;

    // Fixed limits of the cluster finder.
    localparam int unsigned MAX_SIDE_STRIPS = 63;
    localparam int unsigned CHARGE_BITS     = 16;
    localparam logic [15:0] CHARGE_MASK = (CHARGE_BITS >= 16) ? 16'hFFFF :
        16'((32'd1 << CHARGE_BITS) - 32'd1);
    localparam logic [6:0]  IDX_MAX  = 7'd127;
    localparam logic [22:0] CSUM_MAX = 23'h7FFFFF;
    localparam logic [31:0] MSUM_MAX = 32'hFFFFFFFF;

    // Job queue between the front and back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Configuration as seen by the arithmetic.
    typedef struct packed {
        logic [15:0] strip_pitch;
        logic [15:0] centre_offset;
        logic [5:0]  side_strips;
    } scc_cfg_t;

    // One job: an optional run close followed by an optional event summary.
    typedef struct packed {
        logic        do_close;
        logic [6:0]  run_start;
        logic [6:0]  run_end;
        logic [22:0] charge_sum;
        logic [31:0] moment_sum;
        logic        do_summary;
        logic        tracks_ok;
    } scc_job_t;

endpackage

>>> rtl/scc_front.sv
// Front end: accepts strips, tracks open runs and queues close and summary jobs.
// Depends on scc_pkg.
module scc_front
    import scc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_strip_hit,
    input  logic [15:0] s_strip_charge,
    input  logic [7:0]  s_track_count,
    input  logic        s_last_strip,
    input  logic        q_full,
    output logic        q_push,
    output scc_job_t    q_job
);

    logic [6:0]  idx_reg;
    logic        in_run_reg;
    logic [6:0]  start_reg;
    logic [22:0] cs_reg;
    logic [31:0] ms_reg;

    logic        accept;
    logic [15:0] charge;
    logic [6:0]  start_new;
    logic [22:0] cs_new;
    logic [31:0] ms_new;
    logic [23:0] cs_add;
    logic [32:0] ms_add;
    logic [22:0] idx_charge;
    logic [6:0]  end_prev;
    logic        close_prev;
    logic        close_here;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign charge  = s_strip_charge & CHARGE_MASK;

    // Accumulate the run sums with saturation.
    always_comb begin
        idx_charge = 23'(idx_reg * charge);
        cs_add     = {1'b0, cs_reg} + 24'(charge);
        ms_add     = {1'b0, ms_reg} + 33'(idx_charge);
        if (!in_run_reg) begin
            start_new = idx_reg;
            cs_new    = 23'(charge);
            ms_new    = 32'(idx_charge);
        end else begin
            start_new = start_reg;
            cs_new    = cs_add[23] ? CSUM_MAX : cs_add[22:0];
            ms_new    = ms_add[32] ? MSUM_MAX : ms_add[31:0];
        end
    end

    // A miss closes the open run at the previous strip.
    always_comb begin
        end_prev = (idx_reg == 7'd0) ? 7'd0 : idx_reg - 7'd1;
        if (end_prev < start_reg) begin
            end_prev = start_reg;
        end
    end

    assign close_prev = !s_strip_hit && in_run_reg;
    assign close_here = s_strip_hit && s_last_strip;

    // Build the job for this strip.
    always_comb begin
        q_job.do_close   = close_prev || close_here;
        q_job.run_start  = close_here ? start_new : start_reg;
        q_job.run_end    = close_here ? idx_reg : end_prev;
        q_job.charge_sum = close_here ? cs_new : cs_reg;
        q_job.moment_sum = close_here ? ms_new : ms_reg;
        q_job.do_summary = s_last_strip;
        q_job.tracks_ok  = s_track_count < 8'd3;
    end

    assign q_push = accept && (close_prev || s_last_strip);

    // Event state; the last strip clears it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            in_run_reg <= 1'b0;
            start_reg  <= '0;
            cs_reg     <= '0;
            ms_reg     <= '0;
        end else if (accept) begin
            if (s_last_strip) begin
                idx_reg    <= '0;
                in_run_reg <= 1'b0;
                start_reg  <= '0;
                cs_reg     <= '0;
                ms_reg     <= '0;
            end else begin
                idx_reg    <= (idx_reg >= IDX_MAX) ? IDX_MAX : idx_reg + 7'd1;
                in_run_reg <= s_strip_hit;
                if (s_strip_hit) begin
                    start_reg <= start_new;
                    cs_reg    <= cs_new;
                    ms_reg    <= ms_new;
                end
            end
        end
    end

endmodule

>>> rtl/scc_queue.sv
// Small job queue between the front end and the arithmetic back end.
// Depends on scc_pkg.
module scc_queue
    import scc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  scc_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output scc_job_t head_job
);

    scc_job_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign full     = count_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign head_job = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/scc_back.sv
// Back end: computes binary and weighted positions, tracks the longest run
// and drives the result register. Depends on scc_pkg and the macros header.
`include "strip_cluster_centroid_unit_macros.svh"
module scc_back
    import scc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  scc_cfg_t           cfg,
    input  logic               q_empty,
    input  scc_job_t           q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_summary,
    output logic signed [24:0] m_binary_position,
    output logic signed [24:0] m_weighted_position,
    output logic               m_longest_valid,
    output logic               m_event_end
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL1, ST_MUL2, ST_DIVSET, ST_DIV, ST_WT, ST_CLOSE_OUT, ST_SUM_OUT
    } state_t;

    localparam logic signed [24:0] POS_MIN = -25'sd16777216;
    localparam logic signed [24:0] POS_MAX = 25'sd16777215;

    state_t             state_reg;
    scc_job_t           job_reg;
    logic signed [34:0] kp_reg;
    logic signed [41:0] bq_reg;
    logic signed [59:0] n_reg;
    logic signed [24:0] bin_reg;
    logic signed [24:0] wt_reg;
    logic               neg_reg;
    logic [59:0]        quo_reg;
    logic [30:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic [7:0]         best_len_reg;
    logic signed [24:0] best_bin_reg;
    logic signed [24:0] best_wt_reg;
    logic               have_best_reg;
    logic               m_valid_reg;
    logic               is_summary_reg;
    logic signed [24:0] bin_out_reg;
    logic signed [24:0] wt_out_reg;
    logic               longest_valid_reg;
    logic               event_end_reg;

    logic [5:0]         side_cl;
    logic signed [17:0] base;
    logic signed [16:0] pitch_s;
    logic [7:0]         pos_sum;
    logic signed [17:0] k_val;
    logic signed [41:0] diff;
    logic signed [58:0] prod;
    logic signed [34:0] bin_round;
    logic signed [26:0] bin_shift;
    logic signed [24:0] bin_sat;
    logic signed [59:0] num;
    logic [30:0]        divisor;
    logic [59:0]        mag;
    logic [31:0]        rem_sh;
    logic               q_bit;
    logic [30:0]        rem_new;
    logic signed [24:0] wt_div;
    logic [7:0]         run_len;
    logic               out_free;
    logic               sum_valid;

    // Centre of the detector in signed Q10.8 strips.
    always_comb begin
        side_cl = (32'(cfg.side_strips) > MAX_SIDE_STRIPS) ? 6'(MAX_SIDE_STRIPS)
                                                            : cfg.side_strips;
        base    = $signed({4'b0, side_cl, 8'b0})
                + $signed({{2{cfg.centre_offset[15]}}, cfg.centre_offset});
        pitch_s = $signed({1'b0, cfg.strip_pitch});
        pos_sum = {1'b0, job_reg.run_start} + {1'b0, job_reg.run_end};
        k_val   = $signed({3'b0, pos_sum, 7'b0}) - base;
    end

    // Weighted numerator and binary position rounding.
    always_comb begin
        diff      = $signed({2'b0, job_reg.moment_sum, 8'b0}) - bq_reg;
        prod      = diff * pitch_s;
        bin_round = kp_reg + 35'sd128;
        bin_shift = 27'(bin_round >>> 8);
        if (bin_shift < 27'(POS_MIN)) begin
            bin_sat = POS_MIN;
        end else if (bin_shift > 27'(POS_MAX)) begin
            bin_sat = POS_MAX;
        end else begin
            bin_sat = bin_shift[24:0];
        end
    end

    // Floor division setup: negative numerators divide their magnitude rounded up.
    always_comb begin
        num     = n_reg + $signed({30'b0, job_reg.charge_sum, 7'b0});
        divisor = {job_reg.charge_sum, 8'b0};
        if (num < 0) begin
            mag = 60'(-num) + {29'b0, divisor} - 60'd1;
        end else begin
            mag = num;
        end
    end

    // One restoring division step per cycle.
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[59]};
        q_bit   = rem_sh >= {1'b0, divisor};
        rem_new = q_bit ? 31'(rem_sh - {1'b0, divisor}) : rem_sh[30:0];
    end

    // Saturate the quotient to the position range.
    always_comb begin
        if (!neg_reg) begin
            wt_div = (quo_reg > 60'(POS_MAX)) ? POS_MAX : quo_reg[24:0];
        end else begin
            wt_div = (quo_reg > 60'd16777216) ? POS_MIN : -$signed(quo_reg[24:0]);
        end
    end

    assign run_len   = 8'(job_reg.run_end - job_reg.run_start) + 8'd1;
    assign out_free  = !m_valid_reg || m_ready;
    assign sum_valid = have_best_reg && job_reg.tracks_ok;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    // Sequencer, longest-run record and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_best_reg <= 1'b0;
            best_len_reg  <= '0;
            best_bin_reg  <= '0;
            best_wt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= q_head;
                        state_reg <= q_head.do_close ? ST_MUL1 : ST_SUM_OUT;
                    end
                end
                ST_MUL1: begin
                    kp_reg    <= k_val * pitch_s;
                    bq_reg    <= base * $signed({1'b0, job_reg.charge_sum});
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    n_reg   <= {prod[58], prod};
                    bin_reg <= bin_sat;
                    if (job_reg.charge_sum == '0) begin
                        wt_reg    <= POS_MIN;
                        state_reg <= ST_CLOSE_OUT;
                    end else begin
                        state_reg <= ST_DIVSET;
                    end
                end
                ST_DIVSET: begin
                    neg_reg   <= num < 0;
                    quo_reg   <= mag;
                    rem_reg   <= '0;
                    cnt_reg   <= 6'd59;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= rem_new;
                    quo_reg <= {quo_reg[58:0], q_bit};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_WT;
                    end
                end
                ST_WT: begin
                    wt_reg    <= wt_div;
                    state_reg <= ST_CLOSE_OUT;
                end
                ST_CLOSE_OUT: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        is_summary_reg    <= 1'b0;
                        bin_out_reg       <= bin_reg;
                        wt_out_reg        <= wt_reg;
                        longest_valid_reg <= 1'b0;
                        event_end_reg     <= 1'b0;
                        if (!have_best_reg || run_len >= best_len_reg) begin
                            have_best_reg <= 1'b1;
                            best_len_reg  <= run_len;
                            best_bin_reg  <= bin_reg;
                            best_wt_reg   <= wt_reg;
                        end
                        state_reg <= job_reg.do_summary ? ST_SUM_OUT : ST_IDLE;
                    end
                end
                ST_SUM_OUT: begin
                    if (out_free) begin
                        m_valid_reg       <= 1'b1;
                        is_summary_reg    <= 1'b1;
                        bin_out_reg       <= sum_valid ? best_bin_reg : '0;
                        wt_out_reg        <= sum_valid ? best_wt_reg : '0;
                        longest_valid_reg <= sum_valid;
                        event_end_reg     <= 1'b1;
                        have_best_reg     <= 1'b0;
                        best_len_reg      <= '0;
                        best_bin_reg      <= '0;
                        best_wt_reg       <= '0;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_is_summary        = is_summary_reg;
    assign m_binary_position   = bin_out_reg;
    assign m_weighted_position = wt_out_reg;
    assign m_longest_valid     = longest_valid_reg;
    assign m_event_end         = event_end_reg;

    `SCC_ASSERT_IMP(a_cluster_flags, aclk, aresetn, m_valid_reg && !is_summary_reg, !event_end_reg && !longest_valid_reg, "cluster result carries summary flags")
    `SCC_ASSERT_IMP(a_invalid_zero, aclk, aresetn, m_valid_reg && is_summary_reg && !longest_valid_reg, bin_out_reg == '0 && wt_out_reg == '0, "invalid summary has nonzero positions")
    `SCC_ASSERT_IMP(a_div_nonzero, aclk, aresetn, state_reg == ST_DIV, job_reg.charge_sum != '0, "division entered with zero charge")
    `SCC_ASSERT_NXT(a_pop_starts, aclk, aresetn, state_reg == ST_IDLE && !q_empty, state_reg != ST_IDLE, "popped job not started")

endmodule

>>> rtl/strip_cluster_centroid_unit.sv
// Strip cluster centroid unit. Strips are taken one per cycle while the job queue
// has room; a closed run passes through the back end's bit-serial divider, which
// is skipped when its charge sum is zero. The back end works on one job at a time
// and takes no new job from the queue until the last one's results are out.
// Synchronous active-low reset clears event state and loads default configuration.
module strip_cluster_centroid_unit
    import scc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_strip_hit,
    input  logic [15:0]        s_strip_charge,
    input  logic [7:0]         s_track_count,
    input  logic               s_last_strip,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_summary,
    output logic signed [24:0] m_binary_position,
    output logic signed [24:0] m_weighted_position,
    output logic               m_longest_valid,
    output logic               m_event_end
);

    scc_cfg_t cfg_reg;
    scc_job_t push_job;
    scc_job_t head_job;
    logic     q_full;
    logic     q_empty;
    logic     q_push;
    logic     q_pop;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.strip_pitch   <= PITCH_RESET;
            cfg_reg.centre_offset <= OFFSET_RESET;
            cfg_reg.side_strips   <= SIDE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STRIP_PITCH:   cfg_reg.strip_pitch   <= cfg_wdata;
                CFG_CENTRE_OFFSET: cfg_reg.centre_offset <= cfg_wdata;
                CFG_SIDE_STRIPS:   cfg_reg.side_strips   <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    scc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_strip_hit    (s_strip_hit),
        .s_strip_charge (s_strip_charge),
        .s_track_count  (s_track_count),
        .s_last_strip   (s_last_strip),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    scc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    scc_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg                 (cfg_reg),
        .q_empty             (q_empty),
        .q_head              (head_job),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_is_summary        (m_is_summary),
        .m_binary_position   (m_binary_position),
        .m_weighted_position (m_weighted_position),
        .m_longest_valid     (m_longest_valid),
        .m_event_end         (m_event_end)
    );

endmodule

>>> verif/strip_cluster_centroid_unit_test.sv
// Self-checking testbench for strip_cluster_centroid_unit: random strip events are
// driven and each cluster and summary result is checked against an event predictor.
// Depends on scc_pkg and the strip_cluster_centroid_unit RTL.
`timescale 1ns / 100ps

module strip_cluster_centroid_unit_test;
    import scc_pkg::*;

    localparam longint POS_LO = -64'sd16777216;
    localparam longint POS_HI = 64'sd16777215;
    localparam int STALL_LIMIT = 20000;

    // One result as the block presents it.
    typedef struct packed {
        logic               is_summary;
        logic signed [24:0] binary_position;
        logic signed [24:0] weighted_position;
        logic               longest_valid;
        logic               event_end;
    } cluster_result_t;

    // Predicts results of one event stream and checks them in order.
    class centroid_scoreboard;
        logic [15:0] pitch;
        logic [15:0] offset;
        logic [5:0]  side;
        logic [6:0]  strip_idx;
        bit          open_run;
        logic [6:0]  first_strip;
        logic [22:0] q_sum;
        logic [31:0] m_sum;
        logic [7:0]  best_len;
        logic [24:0] best_bin;
        logic [24:0] best_wt;
        bit          have_best;
        cluster_result_t pending[$];
        int errors;

        function new();
            pitch = PITCH_RESET;
            offset = OFFSET_RESET;
            side = SIDE_RESET;
            errors = 0;
            clear_event();
        endfunction

        function void clear_event();
            strip_idx = 0;
            open_run = 0;
            first_strip = 0;
            q_sum = 0;
            m_sum = 0;
            best_len = 0;
            best_bin = 0;
            best_wt = 0;
            have_best = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_STRIP_PITCH: pitch = val;
                CFG_CENTRE_OFFSET: offset = val;
                CFG_SIDE_STRIPS: side = val[5:0];
                default: ;
            endcase
        endfunction

        function longint floor_quot(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d) != 0 && n < 0) q--;
            return q;
        endfunction

        function longint clamp25(longint v);
            if (v < POS_LO) return POS_LO;
            if (v > POS_HI) return POS_HI;
            return v;
        endfunction

        // Closes the open run at end_strip and queues its cluster result.
        function void close_cluster(logic [6:0] end_strip);
            longint p, base, k, b, w, q, n;
            int unsigned e, len;
            cluster_result_t r;
            p = longint'(pitch);
            base = 256 * longint'(side > MAX_SIDE_STRIPS ? MAX_SIDE_STRIPS : side)
                + longint'($signed(offset));
            e = (end_strip < first_strip) ? first_strip : end_strip;
            k = 128 * (longint'(first_strip) + longint'(e)) - base;
            b = clamp25(floor_quot(k * p + 128, 256));
            len = e - first_strip + 1;
            if (q_sum == 0) begin
                w = POS_LO;
            end else begin
                q = longint'(q_sum);
                n = 256 * longint'(m_sum) * p - base * p * q;
                w = clamp25(floor_quot(n + 128 * q, 256 * q));
            end
            if (!have_best || len >= best_len) begin
                have_best = 1;
                best_len = len[7:0];
                best_bin = b[24:0];
                best_wt = w[24:0];
            end
            r = '{1'b0, b[24:0], w[24:0], 1'b0, 1'b0};
            pending = {pending, r};
            open_run = 0;
        endfunction

        // Notes one accepted strip and queues the results it causes.
        function void note_strip(bit hit, logic [15:0] charge, logic [7:0] tracks, bit last);
            logic [15:0] c;
            longint cs, ms;
            bit ok;
            cluster_result_t r;
            c = charge & CHARGE_MASK;
            if (hit) begin
                if (!open_run) begin
                    open_run = 1;
                    first_strip = strip_idx;
                    q_sum = 0;
                    m_sum = 0;
                end
                cs = longint'(q_sum) + longint'(c);
                ms = longint'(m_sum) + longint'(strip_idx) * longint'(c);
                q_sum = (cs > longint'(CSUM_MAX)) ? CSUM_MAX : cs[22:0];
                m_sum = (ms > longint'(MSUM_MAX)) ? MSUM_MAX : ms[31:0];
            end else if (open_run) begin
                close_cluster(strip_idx == 0 ? 7'd0 : strip_idx - 7'd1);
            end
            if (last) begin
                if (open_run) close_cluster(strip_idx);
                ok = have_best && tracks < 3;
                r = '{1'b1, ok ? best_bin : 25'd0, ok ? best_wt : 25'd0, ok, 1'b1};
                pending = {pending, r};
                clear_event();
            end else if (strip_idx != IDX_MAX) begin
                strip_idx++;
            end
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(cluster_result_t got);
            cluster_result_t exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result transfer: %p", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.is_summary !== exp_r.is_summary) begin
                $error("is_summary: expected %0d, got %0d", exp_r.is_summary, got.is_summary);
                errors++;
            end
            if (got.binary_position !== exp_r.binary_position) begin
                $error("binary_position: expected %0d, got %0d",
                    exp_r.binary_position, got.binary_position);
                errors++;
            end
            if (got.weighted_position !== exp_r.weighted_position) begin
                $error("weighted_position: expected %0d, got %0d",
                    exp_r.weighted_position, got.weighted_position);
                errors++;
            end
            if (got.longest_valid !== exp_r.longest_valid) begin
                $error("longest_valid: expected %0d, got %0d",
                    exp_r.longest_valid, got.longest_valid);
                errors++;
            end
            if (got.event_end !== exp_r.event_end) begin
                $error("event_end: expected %0d, got %0d", exp_r.event_end, got.event_end);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [1:0] cfg_index = CFG_STRIP_PITCH;
    logic [15:0] cfg_wdata = 0;
    logic s_valid = 0;
    logic s_ready;
    logic s_strip_hit = 0;
    logic [15:0] s_strip_charge = 0;
    logic [7:0] s_track_count = 0;
    logic s_last_strip = 0;
    logic m_valid;
    logic m_ready = 0;
    logic m_is_summary;
    logic signed [24:0] m_binary_position;
    logic signed [24:0] m_weighted_position;
    logic m_longest_valid;
    logic m_event_end;

    centroid_scoreboard board = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    strip_cluster_centroid_unit dut (.*);

    always #4 aclk = ~aclk;

    // Result side: stall at random, check each transfer, and watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                board.check_result('{m_is_summary, m_binary_position, m_weighted_position,
                    m_longest_valid, m_event_end});
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("strip_cluster_centroid_unit test failed");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Drives one strip and waits for its transfer; valid stays up for the next strip.
    task automatic send_strip(bit hit, logic [15:0] charge, logic [7:0] tracks, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_strip_hit <= hit;
        s_strip_charge <= charge;
        s_track_count <= tracks;
        s_last_strip <= last;
        do @(posedge aclk); while (!s_ready);
        board.note_strip(hit, charge, tracks, last);
        @(negedge aclk);
    endtask

    // Waits until every expected result has arrived, then lets the back end drain.
    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 0;
        board.write_reg(idx, val);
        @(negedge aclk);
    endtask

    // One random event: mostly short runs with random charge, few strips overall.
    task automatic random_event(int strips);
        bit hit;
        logic [15:0] q;
        for (int i = 0; i < strips; i++) begin
            hit = ($urandom_range(99) < 45);
            case ($urandom_range(9))
                0: q = 16'h0000;
                1: q = 16'hFFFF;
                default: q = 16'($urandom());
            endcase
            send_strip(hit, q, (i == strips - 1) ? 8'($urandom_range(5) +
                ($urandom_range(9) == 0 ? $urandom_range(250) : 0)) : 8'($urandom()),
                i == strips - 1);
        end
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: reset configuration, edge charges, lone strips and ties.
        send_strip(1, 16'hFFFF, 8'd0, 0);
        send_strip(1, 16'h0000, 8'd0, 0);
        send_strip(0, 16'h1234, 8'd0, 0);
        send_strip(1, 16'h0000, 8'd0, 0);
        send_strip(0, 16'h0000, 8'd0, 0);
        send_strip(1, 16'h00FF, 8'd2, 1);
        send_strip(0, 16'h0000, 8'd0, 1);
        send_strip(1, 16'h5555, 8'd3, 1);
        send_strip(1, 16'hAAAA, 8'hFF, 0);
        send_strip(1, 16'h0001, 8'd1, 1);
        drain();

        // Directed: more than 127 strips, one long saturating run.
        for (int i = 0; i < 140; i++) send_strip(1, 16'hFFFF, 8'd0, i == 139);
        drain();

        // Extreme settings, including a zero pitch.
        write_reg(CFG_STRIP_PITCH, 16'hFFFF);
        write_reg(CFG_CENTRE_OFFSET, 16'h8000);
        write_reg(CFG_SIDE_STRIPS, 16'd63);
        random_event(6);
        drain();
        write_reg(CFG_STRIP_PITCH, 16'd0);
        write_reg(CFG_CENTRE_OFFSET, 16'h7FFF);
        write_reg(CFG_SIDE_STRIPS, 16'd0);
        random_event(6);
        drain();
        write_reg(CFG_STRIP_PITCH, 16'd1);
        random_event(5);
        drain();

        // Random phases with different idling and settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            write_reg(CFG_STRIP_PITCH, 16'($urandom()));
            write_reg(CFG_CENTRE_OFFSET, 16'($urandom()));
            write_reg(CFG_SIDE_STRIPS, 16'($urandom_range(63)));
            for (int n = 0; n < 112; n += 0) begin
                int len;
                len = $urandom_range(12, 1);
                random_event(len);
                n += len;
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("strip_cluster_centroid_unit test passed");
        end else begin
            if (board.pending.size() != 0)
                $error("%0d expected results never arrived", board.pending.size());
            $display("strip_cluster_centroid_unit test failed");
        end
        $finish;
    end
endmodule
